/* sv/smc_pkg.sv */
`default_nettype none

package smc_pkg;

    localparam int unsigned HIST_W   = 64;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned THR_W    = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned LANES    = HIST_W / 8;
    localparam int unsigned LANE_CNT_W = 4;

    localparam logic [HIST_W-1:0] MARKER_RESET  = 64'h0347_76C7_2728_95B0;
    localparam logic [HIST_W-1:0] ROTATED_RESET = 64'hA921_1361_B1BE_C0DA;
    localparam logic [HIST_W-1:0] MASK_ALL      = {HIST_W{1'b1}};
    localparam logic [LEN_W-1:0]  LEN_MAX       = LEN_W'(HIST_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROTATION_MODE  = 3'd0,
        REG_MARKER_LENGTH  = 3'd1,
        REG_THRESHOLD      = 3'd2,
        REG_MARKER_WORD    = 3'd3,
        REG_ROTATED_WORD   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                rotation_mode;
        logic [LEN_W-1:0]    eff_len;
        logic [THR_W-1:0]    threshold;
        logic [HIST_W-1:0]   mask;
        logic [HIST_W-1:0]   marker;
        logic [HIST_W-1:0]   rotated;
    } cfg_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } load_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [HIST_W-1:0]          diff;
        logic [HIST_W-1:0]          diff90;
        logic                       filling;
    } stage1_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]           sample;
        logic [LANES-1:0][LANE_CNT_W-1:0]     part;
        logic [LANES-1:0][LANE_CNT_W-1:0]     part90;
        logic                                 filling;
    } stage2_t;

    function automatic logic [LANE_CNT_W-1:0] ones8(input logic [7:0] v);
        logic [LANE_CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + LANE_CNT_W'(v[i]);
        end
        return n;
    endfunction

    // match, or inverted match; evaluated without wrap
    function automatic logic meets_rule(input logic [LEN_W-1:0] cnt,
                                        input logic [THR_W-1:0] thr,
                                        input logic [LEN_W-1:0] len);
        logic [LEN_W:0] total;
        total = {1'b0, cnt} + (LEN_W+1)'(thr);
        return (cnt <= LEN_W'(thr)) || (total >= (LEN_W+1)'(len));
    endfunction

endpackage

`default_nettype wire

/* sv/smc_sample_if.sv */
`default_nettype none

interface smc_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [smc_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* sv/smc_result_if.sv */
`default_nettype none

interface smc_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [smc_pkg::SAMPLE_W-1:0]   sample_out;
    logic                                  marker_found;
    logic [smc_pkg::LEN_W-1:0]             mismatch_count;

    modport source (output valid, output sample_out, output marker_found,
                    output mismatch_count, input ready);
    modport sink   (input valid, input sample_out, input marker_found,
                    input mismatch_count, output ready);
endinterface

`default_nettype wire

/* sv/smc_cfg_if.sv */
`default_nettype none

interface smc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [smc_pkg::CFG_IDX_W-1:0]     index;
    logic [smc_pkg::HIST_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/smc_cfg.sv */
`default_nettype none

module smc_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    smc_cfg_if.sink          cfg,
    output smc_pkg::cfg_t    regs
);
    import smc_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [LEN_W-1:0] len_clamped;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        if (cfg.data[LEN_W-1:0] == '0)
            len_clamped = LEN_W'(1);
        else if (cfg.data[LEN_W-1:0] > LEN_MAX)
            len_clamped = LEN_MAX;
        else
            len_clamped = cfg.data[LEN_W-1:0];
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_ROTATION_MODE: cfg_next.rotation_mode = cfg.data[0];
                REG_MARKER_LENGTH:
                begin
                    cfg_next.eff_len = len_clamped;
                    cfg_next.mask    = MASK_ALL >> (LEN_MAX - len_clamped);
                end
                REG_THRESHOLD:     cfg_next.threshold = cfg.data[THR_W-1:0];
                REG_MARKER_WORD:   cfg_next.marker    = cfg.data;
                REG_ROTATED_WORD:  cfg_next.rotated   = cfg.data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation_mode <= 1'b0;
            cfg_reg.eff_len       <= LEN_MAX;
            cfg_reg.threshold     <= '0;
            cfg_reg.mask          <= MASK_ALL;
            cfg_reg.marker        <= MARKER_RESET;
            cfg_reg.rotated       <= ROTATED_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* sv/smc_front.sv */
`default_nettype none

module smc_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire logic signed [smc_pkg::SAMPLE_W-1:0] sample,
    input  smc_pkg::cfg_t                         regs,
    output smc_pkg::stage1_t                      stage
);
    import smc_pkg::*;

    logic [HIST_W-1:0] history_reg;
    logic [HIST_W-1:0] history_next;
    logic [LEN_W-1:0]  fill_reg;
    logic [LEN_W-1:0]  fill_next;
    logic              filling;
    stage1_t           stage_reg;

    assign filling = fill_reg < regs.eff_len;
    assign stage   = stage_reg;

    always_comb
    begin
        history_next = history_reg;
        fill_next    = fill_reg;
        if (load)
        begin
            // sign clear means zero or positive, sliced to one
            history_next = {history_reg[HIST_W-2:0], ~sample[SAMPLE_W-1]};
            if (filling)
                fill_next = fill_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            history_reg <= history_next;
            fill_reg    <= fill_next;
        end
    end

    // compare against the history as it stood before this bit
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg.sample  <= sample;
            stage_reg.diff    <= (history_reg ^ regs.marker) & regs.mask;
            stage_reg.diff90  <= (history_reg ^ regs.rotated) & regs.mask;
            stage_reg.filling <= filling;
        end
    end

endmodule

`default_nettype wire

/* sv/smc_count.sv */
`default_nettype none

module smc_count (
    input  wire logic                 clk,
    input  smc_pkg::load_t            load,
    input  smc_pkg::stage1_t          stage,
    input  smc_pkg::cfg_t             regs,
    output logic signed [smc_pkg::SAMPLE_W-1:0] sample_out,
    output logic                      marker_found,
    output logic [smc_pkg::LEN_W-1:0] mismatch_count
);
    import smc_pkg::*;

    stage2_t                 s2_reg;
    stage2_t                 s2_next;
    logic [LEN_W-1:0]        sum;
    logic [LEN_W-1:0]        sum90;
    logic [LEN_W-1:0]        cnt;
    logic [LEN_W-1:0]        cnt90;
    logic [LEN_W-1:0]        fill_cnt;
    logic                    found;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       found_reg;
    logic [LEN_W-1:0]           count_reg;

    always_comb
    begin
        s2_next.sample  = stage.sample;
        s2_next.filling = stage.filling;
        for (int i = 0; i < LANES; i++)
        begin
            s2_next.part[i]   = ones8(stage.diff[i*8 +: 8]);
            s2_next.part90[i] = ones8(stage.diff90[i*8 +: 8]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s2)
            s2_reg <= s2_next;
    end

    always_comb
    begin
        sum   = '0;
        sum90 = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum   = sum + LEN_W'(s2_reg.part[i]);
            sum90 = sum90 + LEN_W'(s2_reg.part90[i]);
        end
    end

    // while the history fills, both counts read threshold plus one
    assign fill_cnt = LEN_W'(regs.threshold) + LEN_W'(1);
    assign cnt      = s2_reg.filling ? fill_cnt : sum;
    assign cnt90    = s2_reg.filling ? fill_cnt : sum90;
    assign found    = meets_rule(cnt, regs.threshold, regs.eff_len)
                   || (regs.rotation_mode && meets_rule(cnt90, regs.threshold, regs.eff_len));

    always_ff @(posedge clk)
    begin
        if (load.s3)
        begin
            sample_reg <= s2_reg.sample;
            found_reg  <= found;
            count_reg  <= cnt;
        end
    end

    assign sample_out     = sample_reg;
    assign marker_found   = found_reg;
    assign mismatch_count = count_reg;

endmodule

`default_nettype wire

/* sv/sync_marker_correlator.sv */
// A sample beat accepted into the slice register moves on to the popcount register and then
// to the result register, where it is offered as a result beat; a full stage ahead can hold it.
// Throughput: one sample per cycle through three register stages (slice and xor, per-byte
// popcount, sum and match rules); input stalls only when all three stages hold a beat and
// the result beat is not taken.
// Reset: clears bit history, fill count, stage valids and loads default config.
`default_nettype none

module sync_marker_correlator (
    input  wire logic     clk,
    input  wire logic     rst_n,
    smc_sample_if.sink    symbols,
    smc_result_if.source  results,
    smc_cfg_if.sink       cfg
);
    import smc_pkg::*;

    cfg_t    regs;
    stage1_t stage1;
    load_t   load;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || results.ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign load.s1 = symbols.valid && rdy1;
    assign load.s2 = v1_reg && rdy2;
    assign load.s3 = v2_reg && rdy3;

    assign v1_next = rdy1 ? symbols.valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign symbols.ready = rdy1;
    assign results.valid = v3_reg;

    smc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    smc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load.s1),
        .sample (symbols.sample),
        .regs   (regs),
        .stage  (stage1)
    );

    smc_count u_count (
        .clk            (clk),
        .load           (load),
        .stage          (stage1),
        .regs           (regs),
        .sample_out     (results.sample_out),
        .marker_found   (results.marker_found),
        .mismatch_count (results.mismatch_count)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.mismatch_count <= LEN_MAX)
        else $error("mismatch count above marker width");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !results.ready) |-> !symbols.ready)
        else $error("sample beat taken into a full pipeline");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !results.ready) |-> !load.s3)
        else $error("result register overwritten while stalled");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && rdy3) |=> v3_reg)
        else $error("result lost between count stages");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import smc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned PHASE_ITEMS    = 85;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned TOTAL_PHASES   = 4 + RANDOM_PHASES;
    localparam int unsigned PRESSURE_PHASE = 5;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       marker_found;
        logic [LEN_W-1:0]           mismatch_count;
    } corr_result_t;

    logic clk = 1'b0;
    logic rst_n;

    smc_sample_if symbols_if ();
    smc_result_if results_if ();
    smc_cfg_if    cfg_if ();

    sync_marker_correlator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (symbols_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    always #5 clk = ~clk;

    // shadow of the register file and correlator state
    logic              sh_rotation;
    logic [LEN_W-1:0]  sh_length;
    logic [THR_W-1:0]  sh_threshold;
    logic [HIST_W-1:0] sh_marker;
    logic [HIST_W-1:0] sh_rotated;
    logic [HIST_W-1:0] bit_hist;
    int unsigned       fill_level;

    logic signed [SAMPLE_W-1:0] pending_samples[$];
    corr_result_t               expected_results[$];
    corr_result_t               want_res;

    int unsigned queued_items;
    int unsigned mismatch_total;
    int unsigned phase_no;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned holds_asked;
    int unsigned holds_served;
    int unsigned hold_left;
    int unsigned idle_cycles;

    function automatic int unsigned effective_length();
        if (sh_length == 0)
            return 1;
        if (sh_length > HIST_W)
            return HIST_W;
        return sh_length;
    endfunction

    // true-phase or inverted-phase match, no wrap on the sum
    function automatic bit within_rule(input int unsigned cnt, input int unsigned len);
        return (cnt <= sh_threshold) || (cnt + sh_threshold >= len);
    endfunction

    function automatic corr_result_t correlate(input logic signed [SAMPLE_W-1:0] s);
        corr_result_t      r;
        int unsigned       len;
        int unsigned       cnt;
        int unsigned       cnt90;
        logic [HIST_W-1:0] mask;
        len  = effective_length();
        mask = (len >= HIST_W) ? MASK_ALL : ((64'd1 << len) - 64'd1);
        cnt   = sh_threshold + 1;
        cnt90 = cnt;
        if (fill_level < len)
            fill_level++;
        else
        begin
            cnt   = $countones((bit_hist ^ sh_marker) & mask);
            cnt90 = $countones((bit_hist ^ sh_rotated) & mask);
        end
        bit_hist = {bit_hist[HIST_W-2:0], ~s[SAMPLE_W-1]};
        r.sample_out     = s;
        r.marker_found   = within_rule(cnt, len) || (sh_rotation && within_rule(cnt90, len));
        r.mismatch_count = cnt[LEN_W-1:0];
        return r;
    endfunction

    // soft symbol carrying the given hard bit, magnitudes biased to the edges
    function automatic logic signed [SAMPLE_W-1:0] soft_symbol(input bit b);
        int unsigned mag;
        case ($urandom_range(7))
            0: mag = 0;
            1: mag = 32767;
            2: mag = $urandom_range(0, 15);
            default: mag = $urandom_range(0, 32767);
        endcase
        return b ? SAMPLE_W'(mag) : ~SAMPLE_W'(mag);
    endfunction

    task automatic push_bit(input bit b);
        pending_samples.push_back(soft_symbol(b));
        queued_items++;
    endtask

    // marker or rotated word, maybe inverted, with up to threshold plus two bit flips, oldest bit first
    task automatic queue_marker_run();
        int unsigned       len;
        int unsigned       flips;
        int unsigned       idx;
        logic [HIST_W-1:0] word;
        len = effective_length();
        case ($urandom_range(3))
            0: word = sh_marker;
            1: word = ~sh_marker;
            2: word = sh_rotated;
            default: word = ~sh_rotated;
        endcase
        flips = $urandom_range(0, sh_threshold + 2);
        repeat (flips)
        begin
            idx       = $urandom_range(len - 1);
            word[idx] = ~word[idx];
        end
        for (int i = len - 1; i >= 0; i--)
            push_bit(word[i]);
        repeat ($urandom_range(0, 3))
            push_bit(1'($urandom_range(1)));
    endtask

    // random bits, or a marker cut short
    task automatic queue_noise();
        int unsigned n;
        int unsigned len;
        n   = $urandom_range(1, 24);
        len = effective_length();
        if ($urandom_range(1))
        begin
            for (int i = 0; i < n && i < len; i++)
                push_bit(sh_marker[len - 1 - i]);
        end
        else
        begin
            repeat (n)
                push_bit(1'($urandom_range(1)));
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [HIST_W-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_ROTATION_MODE: sh_rotation  = val[0];
            REG_MARKER_LENGTH: sh_length    = val[LEN_W-1:0];
            REG_THRESHOLD:     sh_threshold = val[THR_W-1:0];
            REG_MARKER_WORD:   sh_marker    = val;
            REG_ROTATED_WORD:  sh_rotated   = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || symbols_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic rot, input logic [LEN_W-1:0] len,
                             input logic [THR_W-1:0] thr, input logic [HIST_W-1:0] mk,
                             input logic [HIST_W-1:0] rk);
        int unsigned target;
        write_reg(REG_ROTATION_MODE, HIST_W'(rot));
        write_reg(REG_MARKER_LENGTH, HIST_W'(len));
        write_reg(REG_THRESHOLD, HIST_W'(thr));
        write_reg(REG_MARKER_WORD, mk);
        write_reg(REG_ROTATED_WORD, rk);
        case (phase_no * 3 / TOTAL_PHASES)
            0:
            begin
                send_idle_pct = 34;
                recv_idle_pct = 57;
            end
            1:
            begin
                send_idle_pct = 57;
                recv_idle_pct = 34;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
        target = queued_items + PHASE_ITEMS;
        while (queued_items < target)
        begin
            if ($urandom_range(99) < 70)
                queue_marker_run();
            else
                queue_noise();
        end
        if (phase_no == PRESSURE_PHASE)
            holds_asked++;
        wait_drained();
        phase_no++;
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbols_if.valid  <= 1'b0;
            symbols_if.sample <= '0;
        end
        else if (!symbols_if.valid || symbols_if.ready)
        begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                symbols_if.valid  <= 1'b1;
                symbols_if.sample <= pending_samples.pop_front();
            end
            else
                symbols_if.valid <= 1'b0;
        end
    end

    // result ready, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            hold_left        <= 0;
            holds_served     <= 0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served     <= holds_asked;
            hold_left        <= HOLD_CYCLES;
            results_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left        <= hold_left - 1;
            results_if.ready <= 1'b0;
        end
        else
            results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check result beats, predict from accepted sample beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, sample_out %0d",
                             $time, results_if.sample_out);
                    mismatch_total++;
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    if (want_res.sample_out !== results_if.sample_out)
                    begin
                        $display("%0t: sample_out expected %0d actual %0d", $time,
                                 want_res.sample_out, results_if.sample_out);
                        mismatch_total++;
                    end
                    if (want_res.marker_found !== results_if.marker_found)
                    begin
                        $display("%0t: marker_found expected %0d actual %0d", $time,
                                 want_res.marker_found, results_if.marker_found);
                        mismatch_total++;
                    end
                    if (want_res.mismatch_count !== results_if.mismatch_count)
                    begin
                        $display("%0t: mismatch_count expected %0d actual %0d", $time,
                                 want_res.mismatch_count, results_if.mismatch_count);
                        mismatch_total++;
                    end
                end
            end
            if (symbols_if.valid && symbols_if.ready)
                expected_results.push_back(correlate(symbols_if.sample));
        end
    end

    // watchdog: cycles with work outstanding and no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (symbols_if.valid && symbols_if.ready)
            || (results_if.valid && results_if.ready) || (cfg_if.valid && cfg_if.ready)
            || (pending_samples.size() == 0 && expected_results.size() == 0
                && !symbols_if.valid && !cfg_if.valid))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [LEN_W-1:0]  len_pick;
        logic [THR_W-1:0]  thr_pick;
        logic [HIST_W-1:0] mk_pick;
        logic [HIST_W-1:0] rk_pick;
        rst_n          = 1'b0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= REG_ROTATION_MODE;
        cfg_if.data   <= '0;
        sh_rotation    = 1'b0;
        sh_length      = LEN_MAX;
        sh_threshold   = '0;
        sh_marker      = MARKER_RESET;
        sh_rotated     = ROTATED_RESET;
        bit_hist       = '0;
        fill_level     = 0;
        queued_items   = 0;
        mismatch_total = 0;
        phase_no       = 0;
        holds_asked    = 0;
        send_idle_pct  = 34;
        recv_idle_pct  = 57;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // sample extremes under the reset settings, history still filling
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh0000);
        pending_samples.push_back(16'shFFFF);
        pending_samples.push_back(16'sh0001);
        pending_samples.push_back(16'shFFFE);
        pending_samples.push_back(16'sh5555);
        pending_samples.push_back(16'shAAAA);
        queued_items = 8;
        wait_drained();

        // out-of-range length clamps to 64; wide threshold flags while filling
        run_phase(1'b1, 7'd127, 6'd32, MARKER_RESET, ROTATED_RESET);
        // shorter length with a full history compares at once
        run_phase(1'b0, 7'd8, 6'd0, {$urandom, $urandom}, {$urandom, $urandom});
        // zero length reads as one; threshold beyond length always matches
        run_phase(1'b1, 7'd0, 6'd63, '0, MASK_ALL);
        run_phase(1'b1, LEN_MAX, 6'd3, MASK_ALL, '0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: len_pick = LEN_W'($urandom_range(1, 16));
                6, 7: len_pick = LEN_W'($urandom_range(17, 63));
                8: len_pick = LEN_MAX;
                default: len_pick = $urandom_range(1) ? '0 : LEN_W'($urandom_range(65, 127));
            endcase
            thr_pick = ($urandom_range(9) == 0) ? THR_W'($urandom_range(0, 63))
                                                : THR_W'($urandom_range(0, 4));
            case ($urandom_range(9))
                0: mk_pick = '0;
                1: mk_pick = MASK_ALL;
                default: mk_pick = {$urandom, $urandom};
            endcase
            case ($urandom_range(9))
                0: rk_pick = '0;
                1: rk_pick = MASK_ALL;
                default: rk_pick = {$urandom, $urandom};
            endcase
            run_phase(1'($urandom_range(1)), len_pick, thr_pick, mk_pick, rk_pick);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_total == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sync_marker_correlator.f */
sv/smc_pkg.sv
sv/smc_sample_if.sv
sv/smc_result_if.sv
sv/smc_cfg_if.sv
sv/smc_cfg.sv
sv/smc_front.sv
sv/smc_count.sv
sv/sync_marker_correlator.sv
verif/tb_top.sv
